FILE: design/ppf_pkg.sv
package ppf_pkg;

    localparam int PortW   = 16;
    localparam int PosW    = 5;
    localparam int ReasonW = 3;
    localparam int CfgIdxW = 2;
    localparam int NumSig  = 6;

    localparam logic [PosW-1:0] SAT_POSITION = 5'd20;

    localparam logic [PortW-1:0] FIRST_PORT_RESET = 16'd6881;
    localparam logic [PortW-1:0] LAST_PORT_RESET  = 16'd6889;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_FIRST_PORT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LAST_PORT  = 2'd1;

    // item kinds and protocol codes
    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    localparam logic [1:0] PROTO_TCP   = 2'd0;
    localparam logic [1:0] PROTO_UDP   = 2'd1;
    localparam logic [1:0] PROTO_OTHER = 2'd2;
    localparam logic [1:0] PROTO_RSVD  = 2'd3;

    // verdict reasons
    localparam logic [ReasonW-1:0] REASON_NONE      = 3'd0;
    localparam logic [ReasonW-1:0] REASON_PORT      = 3'd1;
    localparam logic [ReasonW-1:0] REASON_HANDSHAKE = 3'd2;
    localparam logic [ReasonW-1:0] REASON_DHT       = 3'd3;
    localparam logic [ReasonW-1:0] REASON_UTP       = 3'd4;
    localparam logic [ReasonW-1:0] REASON_TRACKER   = 3'd5;

    // bit positions in the signature vector
    localparam int SIG_HANDSHAKE = 0;
    localparam int SIG_DHT_Q     = 1;
    localparam int SIG_DHT_R     = 2;
    localparam int SIG_DHT_E     = 3;
    localparam int SIG_UTP       = 4;
    localparam int SIG_TRACKER   = 5;

    localparam logic [PosW-1:0] LEN_HANDSHAKE = 5'd20;
    localparam logic [PosW-1:0] LEN_DHT_QR    = 5'd9;
    localparam logic [PosW-1:0] LEN_DHT_E     = 5'd6;
    localparam logic [PosW-1:0] LEN_UTP       = 5'd20;
    localparam logic [PosW-1:0] LEN_TRACKER   = 5'd8;

    localparam logic [7:0] UTP_SYN_TYPE    = 8'h41;
    localparam logic [7:0] UTP_MAX_EXT     = 8'd2;
    localparam logic [PosW-1:0] UTP_ACK_LO = 5'd18;
    localparam logic [PosW-1:0] UTP_ACK_HI = 5'd19;

    localparam logic [7:0] PAT_HANDSHAKE [20] = '{
        8'h13, 8'h42, 8'h69, 8'h74, 8'h54, 8'h6f, 8'h72, 8'h72, 8'h65, 8'h6e,
        8'h74, 8'h20, 8'h70, 8'h72, 8'h6f, 8'h74, 8'h6f, 8'h63, 8'h6f, 8'h6c};
    localparam logic [7:0] PAT_DHT_Q [9] = '{
        8'h64, 8'h31, 8'h3a, 8'h61, 8'h64, 8'h32, 8'h3a, 8'h69, 8'h64};
    localparam logic [7:0] PAT_DHT_R [9] = '{
        8'h64, 8'h31, 8'h3a, 8'h72, 8'h64, 8'h32, 8'h3a, 8'h69, 8'h64};
    localparam logic [7:0] PAT_DHT_E [6] = '{
        8'h64, 8'h31, 8'h3a, 8'h65, 8'h6c, 8'h69};
    localparam logic [7:0] PAT_TRACKER [8] = '{
        8'h00, 8'h00, 8'h04, 8'h17, 8'h27, 8'h10, 8'h19, 8'h80};

    typedef struct packed {
        logic              client_side;
        logic [1:0]        proto_kind;
        logic              port_hit;
        logic [PosW-1:0]   byte_position;
        logic [NumSig-1:0] sig_alive;
    } pkt_state_t;

endpackage

FILE: design/ppf_sig_match.sv
module ppf_sig_match
    import ppf_pkg::*;
(
    input  logic [PosW-1:0]   pos,
    input  logic [7:0]        data_byte,
    input  logic [NumSig-1:0] alive,
    output logic [NumSig-1:0] alive_next
);

    logic [NumSig-1:0] miss;

    always_comb begin
        miss = '0;
        if (pos < LEN_HANDSHAKE && PAT_HANDSHAKE[pos] != data_byte) begin
            miss[SIG_HANDSHAKE] = 1'b1;
        end
        if (pos < LEN_DHT_QR && PAT_DHT_Q[pos[3:0]] != data_byte) begin
            miss[SIG_DHT_Q] = 1'b1;
        end
        if (pos < LEN_DHT_QR && PAT_DHT_R[pos[3:0]] != data_byte) begin
            miss[SIG_DHT_R] = 1'b1;
        end
        if (pos < LEN_DHT_E && PAT_DHT_E[pos[2:0]] != data_byte) begin
            miss[SIG_DHT_E] = 1'b1;
        end
        if (pos < LEN_TRACKER && PAT_TRACKER[pos[2:0]] != data_byte) begin
            miss[SIG_TRACKER] = 1'b1;
        end
        // uTP SYN: type byte, extension limit, zero ack field
        if ((pos == '0 && data_byte != UTP_SYN_TYPE) ||
            (pos == PosW'(1) && data_byte > UTP_MAX_EXT) ||
            ((pos == UTP_ACK_LO || pos == UTP_ACK_HI) && data_byte != 8'h00)) begin
            miss[SIG_UTP] = 1'b1;
        end
        alive_next = alive & ~miss;
    end

endmodule

FILE: design/ppf_verdict.sv
module ppf_verdict
    import ppf_pkg::*;
(
    input  pkt_state_t         pkt,
    output logic               drop,
    output logic [ReasonW-1:0] reason
);

    logic hit_handshake;
    logic hit_dht;
    logic hit_utp;
    logic hit_tracker;

    assign hit_handshake = pkt.sig_alive[SIG_HANDSHAKE] && pkt.byte_position >= LEN_HANDSHAKE;
    assign hit_dht = (pkt.sig_alive[SIG_DHT_Q] && pkt.byte_position >= LEN_DHT_QR) ||
                     (pkt.sig_alive[SIG_DHT_R] && pkt.byte_position >= LEN_DHT_QR) ||
                     (pkt.sig_alive[SIG_DHT_E] && pkt.byte_position >= LEN_DHT_E);
    assign hit_utp     = pkt.sig_alive[SIG_UTP] && pkt.byte_position >= LEN_UTP;
    assign hit_tracker = pkt.sig_alive[SIG_TRACKER] && pkt.byte_position >= LEN_TRACKER;

    always_comb begin
        reason = REASON_NONE;
        if (pkt.client_side) begin
            if (pkt.proto_kind == PROTO_TCP) begin
                priority if (pkt.port_hit) reason = REASON_PORT;
                else if (hit_handshake)    reason = REASON_HANDSHAKE;
            end else if (pkt.proto_kind == PROTO_UDP) begin
                priority if (pkt.port_hit) reason = REASON_PORT;
                else if (hit_dht)          reason = REASON_DHT;
                else if (hit_utp)          reason = REASON_UTP;
                else if (hit_tracker)      reason = REASON_TRACKER;
            end
        end
        drop = (reason != REASON_NONE);
    end

endmodule

FILE: design/p2p_packet_prefix_filter_unit.sv
// Peer-to-peer packet classifier. Feed one header item per packet, then its
// payload bytes with the last one marked; one drop/reason verdict comes out
// after the last byte, or right after a header that has no payload. Items
// enter an input register, the signature compare and verdict logic run
// between it and the result register, so a new item is taken each cycle
// while the input register is empty or the result register is free or being
// read. A verdict shows on m_valid once it reaches the result register and
// stays there until taken. Write the peer port range (index 0 first port,
// index 1 last port) only while idle.
module p2p_packet_prefix_filter_unit
    import ppf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [PortW-1:0]    cfg_data,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic                s_from_client,
    input  logic [1:0]          s_protocol,
    input  logic [PortW-1:0]    s_dest_port,
    input  logic                s_has_payload,
    input  logic [7:0]          s_payload_byte,
    input  logic                s_last_byte,

    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_drop,
    output logic [ReasonW-1:0]  m_reason
);

    logic [PortW-1:0] first_port_reg;
    logic [PortW-1:0] last_port_reg;

    // input register
    logic             in_vld_reg;
    logic             kind_reg;
    logic             from_client_reg;
    logic [1:0]       protocol_reg;
    logic [PortW-1:0] dest_port_reg;
    logic             has_payload_reg;
    logic [7:0]       byte_reg;
    logic             last_reg;

    // packet state
    pkt_state_t pkt_reg;
    pkt_state_t pkt_next;
    logic       open_reg;
    logic       open_next;
    logic       emit;

    // result register
    logic               out_vld_reg;
    logic               drop_reg;
    logic [ReasonW-1:0] reason_reg;

    logic               out_free;
    logic               advance;
    logic [NumSig-1:0]  alive_upd;
    logic               v_drop;
    logic [ReasonW-1:0] v_reason;

    assign out_free = !out_vld_reg || m_ready;
    assign advance  = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_port_reg <= FIRST_PORT_RESET;
            last_port_reg  <= LAST_PORT_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_FIRST_PORT) first_port_reg <= cfg_data;
            if (cfg_index == CFG_LAST_PORT)  last_port_reg  <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg        <= s_kind;
            from_client_reg <= s_from_client;
            protocol_reg    <= s_protocol;
            dest_port_reg   <= s_dest_port;
            has_payload_reg <= s_has_payload;
            byte_reg        <= s_payload_byte;
            last_reg        <= s_last_byte;
        end
    end

    ppf_sig_match u_sig_match (
        .pos        (pkt_reg.byte_position),
        .data_byte  (byte_reg),
        .alive      (pkt_reg.sig_alive),
        .alive_next (alive_upd)
    );

    always_comb begin
        pkt_next  = pkt_reg;
        open_next = open_reg;
        emit      = 1'b0;
        if (kind_reg == KIND_HEADER) begin
            pkt_next.client_side   = from_client_reg;
            pkt_next.proto_kind    = (protocol_reg == PROTO_RSVD) ? PROTO_OTHER : protocol_reg;
            pkt_next.port_hit      = dest_port_reg >= first_port_reg &&
                                     dest_port_reg <= last_port_reg;
            pkt_next.byte_position = '0;
            pkt_next.sig_alive     = has_payload_reg ? '1 : '0;
            open_next              = has_payload_reg;
            emit                   = !has_payload_reg;
        end else if (open_reg) begin
            pkt_next.sig_alive = alive_upd;
            if (pkt_reg.byte_position < SAT_POSITION) begin
                pkt_next.byte_position = pkt_reg.byte_position + PosW'(1);
            end
            if (last_reg) begin
                open_next = 1'b0;
                emit      = 1'b1;
            end
        end
    end

    ppf_verdict u_verdict (
        .pkt    (pkt_next),
        .drop   (v_drop),
        .reason (v_reason)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pkt_reg.client_side   <= 1'b0;
            pkt_reg.proto_kind    <= PROTO_OTHER;
            pkt_reg.port_hit      <= 1'b0;
            pkt_reg.byte_position <= '0;
            pkt_reg.sig_alive     <= '0;
            open_reg              <= 1'b0;
        end else if (advance) begin
            pkt_reg  <= pkt_next;
            open_reg <= open_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= advance && emit;
        end
    end

    // hold the verdict until it is taken
    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            drop_reg   <= v_drop;
            reason_reg <= v_reason;
        end
    end

    assign m_valid  = out_vld_reg;
    assign m_drop   = drop_reg;
    assign m_reason = reason_reg;

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ppf_pkg::*;

    localparam int RESULT_LATENCY = 2;
    localparam int STALL_LIMIT    = 2000;
    localparam int IDLE_PERCENT   = 26;

    localparam logic [CfgIdxW-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_SPARE_3 = 2'd3;

    localparam logic [7:0] UTP_TYPE_SYN  = 8'h41;
    localparam logic [7:0] UTP_EXT_MAX   = 8'd2;
    localparam int         UTP_ACK_FIRST = 18;
    localparam int         POS_LIMIT     = 20;

    // payload shapes; the first six double as bit indexes of the live-prefix vector
    typedef enum int {
        PL_HANDSHAKE, PL_DHT_Q, PL_DHT_R, PL_DHT_E, PL_UTP, PL_TRACKER, PL_RANDOM
    } payload_kind_e;

    typedef struct packed {
        logic               drop;
        logic [ReasonW-1:0] reason;
    } verdict_t;

    typedef logic [7:0] byte_q_t [$];

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CfgIdxW-1:0] cfg_index;
    logic [PortW-1:0]   cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic               s_from_client;
    logic [1:0]         s_protocol;
    logic [PortW-1:0]   s_dest_port;
    logic               s_has_payload;
    logic [7:0]         s_payload_byte;
    logic               s_last_byte;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_drop;
    logic [ReasonW-1:0] m_reason;

    // classifier model state
    logic [PortW-1:0] reg_first;
    logic [PortW-1:0] reg_last;
    logic             pred_client;
    logic [1:0]       pred_proto;
    logic             pred_port_hit;
    logic [PosW-1:0]  pred_pos;
    logic [5:0]       pred_alive;
    logic             pred_open;

    verdict_t pending_verdicts [$];
    verdict_t next_verdict;
    int       items_counted = 0;
    int       mismatches    = 0;
    int       stall_cycles  = 0;
    bit       idle_on       = 1'b1;

    p2p_packet_prefix_filter_unit DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= idle_on ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
    end

    function automatic logic [159:0] sig_pattern(input int k);
        case (k)
            PL_HANDSHAKE: return {8'h13, "BitTorrent protocol"};
            PL_DHT_Q:     return "d1:ad2:id";
            PL_DHT_R:     return "d1:rd2:id";
            PL_DHT_E:     return "d1:eli";
            PL_TRACKER:   return 64'h0000_0417_2710_1980;
            default:      return '0;
        endcase
    endfunction

    function automatic int sig_len(input int k);
        case (k)
            PL_HANDSHAKE: return 20;
            PL_DHT_Q:     return 9;
            PL_DHT_R:     return 9;
            PL_DHT_E:     return 6;
            PL_UTP:       return 20;
            PL_TRACKER:   return 8;
            default:      return 0;
        endcase
    endfunction

    function automatic logic prefix_ok(input int k, input int pos, input logic [7:0] b);
        logic [159:0] pat;
        int len;
        pat = sig_pattern(k);
        len = sig_len(k);
        if (pos >= len) return 1'b1;
        return pat[8*(len-1-pos) +: 8] == b;
    endfunction

    function automatic logic sig_complete(input int k);
        return pred_alive[k] && (int'(pred_pos) >= sig_len(k));
    endfunction

    function automatic verdict_t judge_packet();
        verdict_t v;
        v.reason = REASON_NONE;
        if (pred_client && pred_proto == PROTO_TCP) begin
            if (pred_port_hit) v.reason = REASON_PORT;
            else if (sig_complete(PL_HANDSHAKE)) v.reason = REASON_HANDSHAKE;
        end else if (pred_client && pred_proto == PROTO_UDP) begin
            if (pred_port_hit) v.reason = REASON_PORT;
            else if (sig_complete(PL_DHT_Q) || sig_complete(PL_DHT_R) ||
                     sig_complete(PL_DHT_E)) v.reason = REASON_DHT;
            else if (sig_complete(PL_UTP)) v.reason = REASON_UTP;
            else if (sig_complete(PL_TRACKER)) v.reason = REASON_TRACKER;
        end
        v.drop = (v.reason != REASON_NONE);
        return v;
    endfunction

    function automatic void classify_item(input logic kind, input logic fc,
                                          input logic [1:0] proto,
                                          input logic [PortW-1:0] port,
                                          input logic hp, input logic [7:0] b,
                                          input logic last_flag);
        int pos;
        if (kind == KIND_HEADER) begin
            items_counted++;
            pred_client   = fc;
            pred_proto    = (proto == PROTO_RSVD) ? PROTO_OTHER : proto;
            pred_port_hit = (port >= reg_first) && (port <= reg_last);
            pred_pos      = '0;
            pred_alive    = hp ? 6'h3f : 6'h00;
            pred_open     = hp;
            if (!hp) pending_verdicts.push_back(judge_packet());
            return;
        end
        // drop bytes that arrive outside a packet
        if (!pred_open) return;
        items_counted++;
        pos = int'(pred_pos);
        for (int k = PL_HANDSHAKE; k <= PL_TRACKER; k++) begin
            if (k != PL_UTP && !prefix_ok(k, pos, b)) pred_alive[k] = 1'b0;
        end
        if ((pos == 0 && b != UTP_TYPE_SYN) || (pos == 1 && b > UTP_EXT_MAX) ||
            ((pos == UTP_ACK_FIRST || pos == UTP_ACK_FIRST + 1) && b != 8'h00))
            pred_alive[PL_UTP] = 1'b0;
        if (pos < POS_LIMIT) pred_pos = pred_pos + 1'b1;
        if (last_flag) begin
            pred_open = 1'b0;
            pending_verdicts.push_back(judge_packet());
        end
    endfunction

    function automatic byte_q_t make_payload(input int k, input int len);
        byte_q_t q;
        logic [159:0] pat;
        logic [7:0] b;
        pat = sig_pattern(k);
        for (int p = 0; p < len; p++) begin
            b = 8'($urandom_range(255));
            if (k == PL_UTP) begin
                case (p)
                    0: b = UTP_TYPE_SYN;
                    1: b = 8'($urandom_range(3));
                    UTP_ACK_FIRST, UTP_ACK_FIRST + 1:
                        b = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
                    default: ;
                endcase
            end else if (p < sig_len(k)) begin
                b = pat[8*(sig_len(k)-1-p) +: 8];
            end
            q.push_back(b);
        end
        return q;
    endfunction

    task automatic send_item(input logic kind, input logic fc, input logic [1:0] proto,
                             input logic [PortW-1:0] port, input logic hp,
                             input logic [7:0] b, input logic last_flag);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_from_client  <= fc;
        s_protocol     <= proto;
        s_dest_port    <= port;
        s_has_payload  <= hp;
        s_payload_byte <= b;
        s_last_byte    <= last_flag;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        classify_item(kind, fc, proto, port, hp, b, last_flag);
    endtask

    task automatic send_header(input logic fc, input logic [1:0] proto,
                               input logic [PortW-1:0] port, input logic hp);
        send_item(KIND_HEADER, fc, proto, port, hp, 8'($urandom_range(255)),
                  1'($urandom_range(1)));
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last_flag);
        send_item(KIND_BYTE, 1'($urandom_range(1)), 2'($urandom_range(3)),
                  PortW'($urandom_range(65535)), 1'($urandom_range(1)), b, last_flag);
    endtask

    task automatic send_packet(input logic fc, input logic [1:0] proto,
                               input logic [PortW-1:0] port, input byte_q_t pl,
                               input bit close);
        send_header(fc, proto, port, pl.size() != 0);
        foreach (pl[i]) send_byte(pl[i], close && (i == pl.size() - 1));
    endtask

    // hold the sender until every verdict is out and the pipeline is empty
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY + 2) @(posedge aclk);
    endtask

    task automatic set_port_range(input logic [PortW-1:0] lo, input logic [PortW-1:0] hi);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FIRST_PORT;
        cfg_data  <= lo;
        @(posedge aclk);
        cfg_index <= CFG_LAST_PORT;
        cfg_data  <= hi;
        @(posedge aclk);
        // writes to unused indexes must leave the range alone
        cfg_index <= $urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3;
        cfg_data  <= PortW'($urandom_range(65535));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        reg_first = lo;
        reg_last  = hi;
    endtask

    task automatic test_directed_headers();
        send_header(1'b1, PROTO_TCP, 16'd6881, 1'b0);
        send_header(1'b1, PROTO_TCP, 16'd6889, 1'b0);
        send_header(1'b1, PROTO_UDP, 16'd6880, 1'b0);
        send_header(1'b1, PROTO_UDP, 16'd6890, 1'b0);
        send_header(1'b0, PROTO_TCP, 16'd6885, 1'b0);
        send_header(1'b1, PROTO_OTHER, 16'd6885, 1'b0);
        send_header(1'b1, PROTO_RSVD, 16'd6885, 1'b0);
        send_header(1'b1, PROTO_TCP, 16'd0, 1'b0);
        send_header(1'b1, PROTO_UDP, 16'hffff, 1'b0);
        // bytes with no packet open
        send_byte(8'h13, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    task automatic test_directed_signatures();
        byte_q_t pl;
        pl = make_payload(PL_HANDSHAKE, 20);
        send_packet(1'b1, PROTO_TCP, 16'd80, pl, 1'b1);
        pl.pop_back();
        send_packet(1'b1, PROTO_TCP, 16'd80, pl, 1'b1);
        pl = make_payload(PL_HANDSHAKE, 24);
        send_packet(1'b1, PROTO_TCP, 16'd6881, pl, 1'b1);
        send_packet(1'b0, PROTO_TCP, 16'd80, pl, 1'b1);
        send_packet(1'b1, PROTO_UDP, 16'd80, pl, 1'b1);
        for (int k = PL_DHT_Q; k <= PL_DHT_E; k++) begin
            pl = make_payload(k, sig_len(k) + 3);
            send_packet(1'b1, PROTO_UDP, 16'd6000, pl, 1'b1);
        end
        send_packet(1'b1, PROTO_TCP, 16'd6000, pl, 1'b1);
        pl = make_payload(PL_UTP, 20);
        pl[1]  = UTP_EXT_MAX;
        pl[18] = 8'h00;
        pl[19] = 8'h00;
        send_packet(1'b1, PROTO_UDP, 16'd4000, pl, 1'b1);
        pl[1] = UTP_EXT_MAX + 1'b1;
        send_packet(1'b1, PROTO_UDP, 16'd4000, pl, 1'b1);
        pl[1]  = 8'h00;
        pl[19] = 8'h01;
        send_packet(1'b1, PROTO_UDP, 16'd4000, pl, 1'b1);
        pl[19] = 8'h00;
        pl.pop_back();
        send_packet(1'b1, PROTO_UDP, 16'd4000, pl, 1'b1);
        pl = make_payload(PL_TRACKER, 8);
        send_packet(1'b1, PROTO_UDP, 16'd1337, pl, 1'b1);
        pl = make_payload(PL_TRACKER, 16);
        send_packet(1'b1, PROTO_UDP, 16'd1337, pl, 1'b1);
        // abandon an open packet with a new header
        send_header(1'b1, PROTO_TCP, 16'd80, 1'b1);
        send_byte(8'h13, 1'b0);
        send_byte(8'h42, 1'b0);
        send_header(1'b1, PROTO_UDP, 16'd6881, 1'b0);
        pl.delete();
        repeat (5) pl.push_back(8'hff);
        send_packet(1'b1, PROTO_TCP, 16'd80, pl, 1'b1);
        pl.delete();
        repeat (21) pl.push_back(8'h00);
        send_packet(1'b1, PROTO_UDP, 16'd80, pl, 1'b1);
    endtask

    task automatic test_port_range();
        logic [PortW-1:0] lo_set [5];
        logic [PortW-1:0] hi_set [5];
        logic [PortW-1:0] probe  [6];
        lo_set = '{16'd0, 16'hffff, 16'd0,    16'hffff, 16'd100};
        hi_set = '{16'd0, 16'hffff, 16'hffff, 16'd0,    16'd50};
        for (int i = 0; i < 5; i++) begin
            drain_pipeline();
            set_port_range(lo_set[i], hi_set[i]);
            probe = '{lo_set[i] - 1'b1, lo_set[i], hi_set[i], hi_set[i] + 1'b1,
                      16'd0, 16'hffff};
            foreach (probe[j])
                send_header(1'b1, (j % 2) ? PROTO_UDP : PROTO_TCP, probe[j], 1'b0);
        end
    endtask

    task automatic test_random_phase(input logic [PortW-1:0] lo, input logic [PortW-1:0] hi,
                                     input int n_items);
        int target;
        int r;
        int pl_kind;
        int len;
        logic fc;
        logic [1:0] proto;
        logic [PortW-1:0] port;
        byte_q_t pl;
        bit close;
        drain_pipeline();
        set_port_range(lo, hi);
        target = items_counted + n_items;
        while (items_counted < target) begin
            fc = ($urandom_range(99) < 80);
            r  = $urandom_range(99);
            proto = (r < 45) ? PROTO_TCP : (r < 85) ? PROTO_UDP :
                    ($urandom_range(1) ? PROTO_OTHER : PROTO_RSVD);
            // aim a good share of ports at the edges of the range
            if ($urandom_range(99) < 35)
                port = PortW'(($urandom_range(1) ? reg_first : reg_last) +
                              $urandom_range(4) - 2);
            else
                port = PortW'($urandom_range(65535));
            r = $urandom_range(99);
            if (r < 6 && !pred_open) begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (r < 16) begin
                send_header(fc, proto, port, 1'b0);
            end else begin
                pl_kind = $urandom_range(PL_RANDOM);
                if (pl_kind == PL_RANDOM) len = $urandom_range(1, 24);
                else len = sig_len(pl_kind) + int'($urandom_range(6)) - 2;
                pl = make_payload(pl_kind, len);
                if ($urandom_range(99) < 12)
                    pl[$urandom_range(len - 1)] = 8'($urandom_range(255));
                close = ($urandom_range(99) >= 5);
                send_packet(fc, proto, port, pl, close);
            end
        end
    endtask

    task automatic test_pressure_pause(input int n_items);
        logic [PortW-1:0] lo;
        lo = PortW'($urandom_range(65535));
        test_random_phase(lo, PortW'(lo + $urandom_range(20)), n_items / 2);
        drain_pipeline();
        test_random_phase(lo, PortW'(lo + $urandom_range(20)), n_items - n_items / 2);
    endtask

    task automatic test_no_idle_stretch(input int n_items);
        idle_on = 1'b0;
        test_random_phase(16'd6881, 16'd6889, n_items);
        idle_on = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected verdict, expected none, actual drop=%0d reason=%0d",
                         $time, m_drop, m_reason);
                mismatches++;
            end else begin
                next_verdict = pending_verdicts.pop_front();
                if (m_drop !== next_verdict.drop) begin
                    $display("%0t: drop mismatch, expected %0d, actual %0d",
                             $time, next_verdict.drop, m_drop);
                    mismatches++;
                end
                if (m_reason !== next_verdict.reason) begin
                    $display("%0t: reason mismatch, expected %0d, actual %0d",
                             $time, next_verdict.reason, m_reason);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= CFG_FIRST_PORT;
        cfg_data       <= '0;
        s_valid        <= 1'b0;
        s_kind         <= KIND_HEADER;
        s_from_client  <= 1'b0;
        s_protocol     <= PROTO_TCP;
        s_dest_port    <= '0;
        s_has_payload  <= 1'b0;
        s_payload_byte <= '0;
        s_last_byte    <= 1'b0;
        reg_first      = 16'd6881;
        reg_last       = 16'd6889;
        pred_client    = 1'b0;
        pred_proto     = PROTO_OTHER;
        pred_port_hit  = 1'b0;
        pred_pos       = '0;
        pred_alive     = '0;
        pred_open      = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_headers();
        test_directed_signatures();
        test_port_range();
        test_random_phase(16'd6881, 16'd6889, 250);
        test_pressure_pause(250);
        test_no_idle_stretch(300);
        test_random_phase(16'hffff, 16'd0, 300);
        test_random_phase(16'd0, 16'hffff, 150);

        drain_pipeline();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
